[rtl/core/mrf_pkg.sv]
// Shared types, constants and the framer microprogram.
// Used by every file of the Modbus RTU command framer but mrf_if; depends on nothing.
package mrf_pkg;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] t_step;

    // Command kinds carried in the action field
    typedef enum logic [1:0] {
        ACT_SPEED  = 2'd0,
        ACT_STATUS = 2'd1,
        ACT_ENABLE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // Byte source for one step
    typedef enum logic [3:0] {
        SRC_ADDR,
        SRC_CONST,
        SRC_LH,
        SRC_LL,
        SRC_RH,
        SRC_RL,
        SRC_EN,
        SRC_CRCL,
        SRC_CRCH
    } t_src;

    // Sequencing after a step
    typedef enum logic [1:0] {
        NXT_INC,
        NXT_DISPATCH,
        NXT_END
    } t_nxt;

    typedef struct packed {
        t_src       src;
        logic [7:0] konst;
        logic       crc_en;
        logic       last;
        t_nxt       nxt;
    } t_cw;

    // Control from the sequencer to the datapath
    typedef struct packed {
        logic issue;
        t_cw  cw;
    } t_ctl;

    // Entry steps of each frame body, and the last program step
    localparam t_step ST_SPEED  = t_step'(1);
    localparam t_step ST_STATUS = t_step'(13);
    localparam t_step ST_ENABLE = t_step'(20);
    localparam t_step ST_LAST   = t_step'(26);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  EN_ON    = 8'h0A;
    localparam logic [7:0]  EN_OFF   = 8'h01;

    function automatic t_cw mk(t_src src, logic [7:0] k, logic crc_en, logic last,
                               t_nxt nxt);
        t_cw w;
        w.src    = src;
        w.konst  = k;
        w.crc_en = crc_en;
        w.last   = last;
        w.nxt    = nxt;
        return w;
    endfunction

    // Microprogram: one control word per step
    function automatic t_cw prog_word(t_step s);
        t_cw w;
        case (s)
            5'd0:  w = mk(SRC_ADDR,  8'h00, 1'b1, 1'b0, NXT_DISPATCH);
            // speed write
            5'd1:  w = mk(SRC_CONST, 8'h10, 1'b1, 1'b0, NXT_INC);
            5'd2:  w = mk(SRC_CONST, 8'h11, 1'b1, 1'b0, NXT_INC);
            5'd3:  w = mk(SRC_CONST, 8'h5C, 1'b1, 1'b0, NXT_INC);
            5'd4:  w = mk(SRC_CONST, 8'h00, 1'b1, 1'b0, NXT_INC);
            5'd5:  w = mk(SRC_CONST, 8'h02, 1'b1, 1'b0, NXT_INC);
            5'd6:  w = mk(SRC_CONST, 8'h04, 1'b1, 1'b0, NXT_INC);
            5'd7:  w = mk(SRC_LH,    8'h00, 1'b1, 1'b0, NXT_INC);
            5'd8:  w = mk(SRC_LL,    8'h00, 1'b1, 1'b0, NXT_INC);
            5'd9:  w = mk(SRC_RH,    8'h00, 1'b1, 1'b0, NXT_INC);
            5'd10: w = mk(SRC_RL,    8'h00, 1'b1, 1'b0, NXT_INC);
            5'd11: w = mk(SRC_CRCL,  8'h00, 1'b0, 1'b0, NXT_INC);
            5'd12: w = mk(SRC_CRCH,  8'h00, 1'b0, 1'b1, NXT_END);
            // status read
            5'd13: w = mk(SRC_CONST, 8'h03, 1'b1, 1'b0, NXT_INC);
            5'd14: w = mk(SRC_CONST, 8'h11, 1'b1, 1'b0, NXT_INC);
            5'd15: w = mk(SRC_CONST, 8'hEA, 1'b1, 1'b0, NXT_INC);
            5'd16: w = mk(SRC_CONST, 8'h00, 1'b1, 1'b0, NXT_INC);
            5'd17: w = mk(SRC_CONST, 8'h0E, 1'b1, 1'b0, NXT_INC);
            5'd18: w = mk(SRC_CRCL,  8'h00, 1'b0, 1'b0, NXT_INC);
            5'd19: w = mk(SRC_CRCH,  8'h00, 1'b0, 1'b1, NXT_END);
            // enable or disable write
            5'd20: w = mk(SRC_CONST, 8'h06, 1'b1, 1'b0, NXT_INC);
            5'd21: w = mk(SRC_CONST, 8'h10, 1'b1, 1'b0, NXT_INC);
            5'd22: w = mk(SRC_CONST, 8'h5A, 1'b1, 1'b0, NXT_INC);
            5'd23: w = mk(SRC_CONST, 8'h00, 1'b1, 1'b0, NXT_INC);
            5'd24: w = mk(SRC_EN,    8'h00, 1'b1, 1'b0, NXT_INC);
            5'd25: w = mk(SRC_CRCL,  8'h00, 1'b0, 1'b0, NXT_INC);
            5'd26: w = mk(SRC_CRCH,  8'h00, 1'b0, 1'b1, NXT_END);
            default: w = mk(SRC_CONST, 8'h00, 1'b0, 1'b1, NXT_END);
        endcase
        return w;
    endfunction

    // Entry step of the frame body for a command kind
    function automatic t_step entry_step(logic [1:0] act);
        t_step s;
        case (act)
            ACT_STATUS: s = ST_STATUS;
            ACT_ENABLE: s = ST_ENABLE;
            default:    s = ST_SPEED;
        endcase
        return s;
    endfunction

    // CRC-16/Modbus update by one byte, LSB first
    function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] d);
        logic [15:0] c;
        c = crc_in ^ {8'h00, d};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/core/mrf_if.sv]
// Command and frame-byte channel interfaces (valid/ready).
// Depends on nothing.
interface mrf_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [15:0] spd_left;
    logic signed [15:0] spd_right;
    logic               enable;

    modport source (output valid, action, spd_left, spd_right, enable, input ready);
    modport sink   (input valid, action, spd_left, spd_right, enable, output ready);
endinterface

interface mrf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last;

    modport source (output valid, tx_byte, last, input ready);
    modport sink   (input valid, tx_byte, last, output ready);
endinterface

[rtl/core/modbus_rtu_command_framer.sv]
// Modbus RTU command framer: one byte per cycle, CRC-16/Modbus appended low byte first.
// Start: the accepting edge sets the sequencer busy at step zero, and the byte of that
// step goes to the output register. Frames: 13 bytes per speed write, 8 per status
// read or enable write; one step (one byte) per cycle, a stalled sink holds it.
// Reset (synchronous, active low): sequencer idle, output empty, slave address 1.
// Depends on mrf_pkg, mrf_if, mrf_seq and mrf_dp.
module modbus_rtu_command_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    mrf_cmd_if.sink    i_cmd,
    mrf_byte_if.source o_frame
);

    logic          busy;
    logic          room;
    logic          accept;
    logic          start;
    mrf_pkg::t_ctl ctl;

    // Take a new command when idle, or in the cycle that issues the final byte,
    // so frames go out back to back with no gap.
    assign i_cmd.ready = !busy || (ctl.issue && ctl.cw.nxt == mrf_pkg::NXT_END);
    assign accept      = i_cmd.valid && i_cmd.ready;

    // Drop the unused action code: it is accepted but produces no frame.
    assign start = accept && (i_cmd.action != mrf_pkg::ACT_NONE);

    // Sequencer: step counter walks the program, dispatching on the action
    // after the address byte; issues a step only when the output register has room.
    mrf_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_cmd.action),
        .i_room   (room),
        .o_busy   (busy),
        .o_ctl    (ctl)
    );

    // Datapath: hold the operands, select the byte for each step, advance the CRC
    // on every body byte and register the result byte toward the sink.
    mrf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_load        (start),
        .i_spd_left    (i_cmd.spd_left),
        .i_spd_right   (i_cmd.spd_right),
        .i_enable      (i_cmd.enable),
        .i_ctl         (ctl),
        .o_room        (room),
        .o_frame       (o_frame)
    );

endmodule

[rtl/core/mrf_seq.sv]
// Microprogram sequencer: step counter, program ROM and dispatch.
// Depends on mrf_pkg.
module mrf_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_action,
    input  logic          i_room,
    output logic          o_busy,
    output mrf_pkg::t_ctl o_ctl
);

    logic           r_busy, n_busy;
    mrf_pkg::t_step r_step, n_step;
    logic [1:0]     r_action, n_action;
    mrf_pkg::t_cw   cw;
    logic           issue;

    assign cw    = mrf_pkg::prog_word(r_step);
    assign issue = r_busy && i_room;

    always_comb begin
        n_busy   = r_busy;
        n_step   = r_step;
        n_action = r_action;
        if (i_start) begin
            n_busy   = 1'b1;
            n_step   = '0;
            n_action = i_action;
        end else if (issue) begin
            case (cw.nxt)
                mrf_pkg::NXT_INC:      n_step = r_step + 1'b1;
                mrf_pkg::NXT_DISPATCH: n_step = mrf_pkg::entry_step(r_action);
                mrf_pkg::NXT_END:      n_busy = 1'b0;
                default:               n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_step   <= '0;
            r_action <= '0;
        end else begin
            r_busy   <= n_busy;
            r_step   <= n_step;
            r_action <= n_action;
        end
    end

    assign o_busy    = r_busy;
    assign o_ctl.issue = issue;
    assign o_ctl.cw    = cw;

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= mrf_pkg::ST_LAST))
        else $error("step counter left the program");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && r_step == '0))
        else $error("start did not enter step zero");
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && cw.nxt == mrf_pkg::NXT_END && !i_start) |=> !r_busy)
        else $error("sequencer stayed busy after the last byte");
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && cw.last) |-> (cw.nxt == mrf_pkg::NXT_END))
        else $error("last byte not at end of program");
`endif

endmodule

[rtl/core/mrf_dp.sv]
// Framer datapath: operand hold, byte select, CRC register and output register.
// Depends on mrf_pkg and mrf_if.
module mrf_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_load,
    input  logic signed [15:0] i_spd_left,
    input  logic signed [15:0] i_spd_right,
    input  logic               i_enable,
    input  mrf_pkg::t_ctl      i_ctl,
    output logic               o_room,
    mrf_byte_if.source         o_frame
);

    logic [7:0]  r_addr;
    logic [15:0] r_left, r_right;
    logic        r_enable;
    logic [15:0] r_crc;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic [7:0]  sel_byte;

    always_comb begin
        case (i_ctl.cw.src)
            mrf_pkg::SRC_ADDR:  sel_byte = r_addr;
            mrf_pkg::SRC_CONST: sel_byte = i_ctl.cw.konst;
            mrf_pkg::SRC_LH:    sel_byte = r_left[15:8];
            mrf_pkg::SRC_LL:    sel_byte = r_left[7:0];
            mrf_pkg::SRC_RH:    sel_byte = r_right[15:8];
            mrf_pkg::SRC_RL:    sel_byte = r_right[7:0];
            mrf_pkg::SRC_EN:    sel_byte = r_enable ? mrf_pkg::EN_ON : mrf_pkg::EN_OFF;
            mrf_pkg::SRC_CRCL:  sel_byte = r_crc[7:0];
            mrf_pkg::SRC_CRCH:  sel_byte = r_crc[15:8];
            default:            sel_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= 8'h01;
        end else if (i_cfg_we) begin
            r_addr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_left   <= i_spd_left;
            r_right  <= i_spd_right;
            r_enable <= i_enable;
            r_crc    <= mrf_pkg::CRC_INIT;
        end else if (i_ctl.issue && i_ctl.cw.crc_en) begin
            r_crc <= mrf_pkg::crc_byte(r_crc, sel_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.issue) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_out_byte <= sel_byte;
            r_out_last <= i_ctl.cw.last;
        end
    end

    assign o_room          = !r_out_valid || o_frame.ready;
    assign o_frame.valid   = r_out_valid;
    assign o_frame.tx_byte = r_out_byte;
    assign o_frame.last    = r_out_last;

endmodule

[verif/mrf_frame_checker.sv]
// Frame checker for the Modbus RTU command framer: watches both channels and the
// address writes, predicts every frame byte and compares it. Depends on mrf_pkg, mrf_if.
module mrf_frame_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    mrf_cmd_if         i_cmd,
    mrf_byte_if        i_frame,
    output int         o_fail_count,
    output int         o_pending
);

    localparam logic [15:0] MODBUS_SEED = 16'hFFFF;
    localparam logic [15:0] MODBUS_POLY = 16'hA001;

    localparam logic [7:0] FN_READ_HOLDING = 8'h03;
    localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FN_WRITE_MULTI  = 8'h10;

    localparam logic [15:0] REG_SPEED  = 16'h115C;
    localparam logic [15:0] REG_STATUS = 16'h11EA;
    localparam logic [15:0] REG_ENABLE = 16'h105A;

    localparam logic [15:0] SPEED_REGS  = 16'h0002;
    localparam logic [7:0]  SPEED_BYTES = 8'h04;
    localparam logic [15:0] STATUS_REGS = 16'h000E;
    localparam logic [7:0]  DRIVE_ON    = 8'h0A;
    localparam logic [7:0]  DRIVE_OFF   = 8'h01;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } t_wire_byte;

    t_wire_byte expected_bytes[$];
    logic [7:0] slave_addr;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        slave_addr   = 8'h01;
    end

    // Build the whole request and queue its bytes in wire order
    function automatic void queue_request(mrf_pkg::t_action act, logic [15:0] ls,
                                          logic [15:0] rs, logic en);
        logic [7:0]  body [0:12];
        int          n;
        logic [15:0] crc;
        t_wire_byte  wb;

        body[0] = slave_addr;
        case (act)
            mrf_pkg::ACT_SPEED: begin
                body[1]  = FN_WRITE_MULTI;
                body[2]  = REG_SPEED[15:8];
                body[3]  = REG_SPEED[7:0];
                body[4]  = SPEED_REGS[15:8];
                body[5]  = SPEED_REGS[7:0];
                body[6]  = SPEED_BYTES;
                body[7]  = ls[15:8];
                body[8]  = ls[7:0];
                body[9]  = rs[15:8];
                body[10] = rs[7:0];
                n = 11;
            end
            mrf_pkg::ACT_STATUS: begin
                body[1] = FN_READ_HOLDING;
                body[2] = REG_STATUS[15:8];
                body[3] = REG_STATUS[7:0];
                body[4] = STATUS_REGS[15:8];
                body[5] = STATUS_REGS[7:0];
                n = 6;
            end
            mrf_pkg::ACT_ENABLE: begin
                body[1] = FN_WRITE_SINGLE;
                body[2] = REG_ENABLE[15:8];
                body[3] = REG_ENABLE[7:0];
                body[4] = 8'h00;
                body[5] = en ? DRIVE_ON : DRIVE_OFF;
                n = 6;
            end
            default: return;
        endcase

        crc = MODBUS_SEED;
        for (int i = 0; i < n; i++) begin
            crc = crc ^ {8'h00, body[i]};
            repeat (8) crc = crc[0] ? ((crc >> 1) ^ MODBUS_POLY) : (crc >> 1);
        end
        body[n]     = crc[7:0];
        body[n + 1] = crc[15:8];
        n = n + 2;

        for (int i = 0; i < n; i++) begin
            wb.tx_byte = body[i];
            wb.last    = (i == n - 1);
            expected_bytes.push_back(wb);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_wire_byte want;
        if (!i_rst_n) begin
            slave_addr = 8'h01;
            expected_bytes.delete();
        end else begin
            if (i_frame.valid && i_frame.ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                             $time, i_frame.tx_byte, i_frame.last);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_frame.tx_byte !== want.tx_byte) begin
                        $display("%0t: tx_byte mismatch: expected %02h, actual %02h",
                                 $time, want.tx_byte, i_frame.tx_byte);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_frame.last !== want.last) begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, i_frame.last);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                queue_request(mrf_pkg::t_action'(i_cmd.action), i_cmd.spd_left,
                              i_cmd.spd_right, i_cmd.enable);
            end
            if (i_cfg_we) begin
                slave_addr = i_cfg_wdata;
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

[verif/tb.sv]
// Top of the framer testbench: clock, reset, command stimulus, sink back-pressure
// and the verdict. Depends on mrf_pkg, mrf_if, the framer and mrf_frame_checker.
module tb;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 150;  // long sink hold-off, fills the framer
    localparam int TAIL_CYCLES  = 16;   // settle time after the last expected byte
    localparam int IDLE_PCT     = 36;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 42;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    int fail_count;
    int pending_bytes;
    int idle_pct;

    // Sink hold-off request from the stimulus; the ready process counts it out
    logic hold_req;
    logic hold_started;
    int   hold_left;

    mrf_cmd_if  cmd_if ();
    mrf_byte_if frame_if ();

    modbus_rtu_command_framer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_cmd       (cmd_if),
        .o_frame     (frame_if)
    );

    mrf_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_cmd        (cmd_if),
        .i_frame      (frame_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_bytes)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Drive the sink ready: random idling, or a long hold-off once requested
    initial begin
        frame_if.ready = 1'b0;
        hold_started   = 1'b0;
        hold_left      = 0;
    end

    always @(posedge i_clk) begin : sink_ready
        logic start_hold;
        start_hold = hold_req && !hold_started;
        if (start_hold) begin
            hold_started <= 1'b1;
            hold_left    <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        frame_if.ready <= !start_hold && (hold_left == 0) && ($urandom_range(99) >= idle_pct);
    end

    // Offer one command and hold it until the framer takes it. Ready is sampled at
    // the falling edge, where it is stable for the next rising edge.
    task automatic send_cmd(mrf_pkg::t_action act, logic [15:0] ls, logic [15:0] rs,
                            logic en);
        logic rdy;
        while ($urandom_range(99) < idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.action    <= act;
        cmd_if.spd_left  <= ls;
        cmd_if.spd_right <= rs;
        cmd_if.enable    <= en;
        do begin
            @(negedge i_clk);
            rdy = cmd_if.ready;
            @(posedge i_clk);
        end while (!rdy);
    endtask

    // Pause the sender until every expected byte is out, then let the sequencer settle.
    // This covers commands with no frame, which leave nothing to wait for.
    task automatic drain_frames();
        cmd_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending_bytes != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Write the slave address; only called with the framer idle
    task automatic write_addr(logic [7:0] addr);
        cfg_wdata <= addr;
        cfg_we    <= 1'b1;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [15:0] rand_speed();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // Random commands: mostly real frames with random content, a few unused codes
    // that the framer drops and that do not count toward the batch
    task automatic random_cmds(int count);
        int               sent;
        mrf_pkg::t_action act;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 6) begin
                act = mrf_pkg::ACT_NONE;
            end else begin
                act = mrf_pkg::t_action'($urandom_range(2));
                sent++;
            end
            send_cmd(act, rand_speed(), rand_speed(), 1'($urandom_range(1)));
        end
    endtask

    // One of each frame kind at the current address
    task automatic each_kind();
        send_cmd(mrf_pkg::ACT_SPEED,  16'h8000, 16'h7FFF, 1'b0);
        send_cmd(mrf_pkg::ACT_STATUS, 16'h0000, 16'hFFFF, 1'b1);
        send_cmd(mrf_pkg::ACT_ENABLE, 16'hFFFF, 16'h0000, 1'b1);
    endtask

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] phase_addr [NUM_PHASES];

        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = 8'h00;
        hold_req         = 1'b0;
        idle_pct         = IDLE_PCT;
        cmd_if.valid     = 1'b0;
        cmd_if.action    = mrf_pkg::ACT_SPEED;
        cmd_if.spd_left  = 16'h0000;
        cmd_if.spd_right = 16'h0000;
        cmd_if.enable    = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: speed extremes, every command, unused fields and the unused code,
        // all at the reset address
        send_cmd(mrf_pkg::ACT_SPEED,  16'h7FFF, 16'h8000, 1'b0);
        send_cmd(mrf_pkg::ACT_SPEED,  16'h8000, 16'h7FFF, 1'b1);
        send_cmd(mrf_pkg::ACT_SPEED,  16'h0000, 16'hFFFF, 1'b0);
        send_cmd(mrf_pkg::ACT_SPEED,  16'hFFFF, 16'h0000, 1'b1);
        send_cmd(mrf_pkg::ACT_SPEED,  16'h1234, 16'hABCD, 1'b0);
        send_cmd(mrf_pkg::ACT_STATUS, 16'hFFFF, 16'hFFFF, 1'b1);
        send_cmd(mrf_pkg::ACT_STATUS, 16'h0000, 16'h0000, 1'b0);
        send_cmd(mrf_pkg::ACT_ENABLE, 16'h0000, 16'h0000, 1'b1);
        send_cmd(mrf_pkg::ACT_ENABLE, 16'hFFFF, 16'hFFFF, 1'b0);
        send_cmd(mrf_pkg::ACT_ENABLE, rand_speed(), rand_speed(), 1'b1);
        send_cmd(mrf_pkg::ACT_NONE,   16'hFFFF, 16'hFFFF, 1'b1);
        send_cmd(mrf_pkg::ACT_STATUS, 16'h5A5A, 16'hA5A5, 1'b1);
        send_cmd(mrf_pkg::ACT_NONE,   16'h0000, 16'h0000, 1'b0);
        send_cmd(mrf_pkg::ACT_SPEED,  16'hFFFF, 16'hFFFF, 1'b1);
        drain_frames();

        // Addresses outside the legal slave range go into the frame as given
        write_addr(8'h00);
        each_kind();
        drain_frames();
        write_addr(8'hFF);
        each_kind();
        drain_frames();

        phase_addr[0] = 8'd247;
        phase_addr[1] = 8'd1;
        phase_addr[2] = 8'd248;
        phase_addr[3] = 8'($urandom_range(1, 247));
        phase_addr[4] = 8'($urandom_range(255));
        phase_addr[5] = 8'h00;
        phase_addr[6] = 8'hFF;
        phase_addr[7] = 8'($urandom_range(255));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_addr(phase_addr[ph]);
            // one phase runs at full rate on both sides
            idle_pct = (ph == 2) ? 0 : IDLE_PCT;
            // one phase starts with a long sink hold-off while commands keep coming
            if (ph == 4) begin
                hold_req <= 1'b1;
            end
            random_cmds(PHASE_ITEMS);
            drain_frames();
        end

        if (fail_count == 0 && pending_bytes == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
